[rtl/core/led_flash_fade_controller_core_macros.svh]
// ----------------------------------------------------------------------------
// LED flash/fade controller assertion macros
// Concurrent check wrappers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef LED_FLASH_FADE_CONTROLLER_CORE_MACROS_SVH
`define LED_FLASH_FADE_CONTROLLER_CORE_MACROS_SVH
`ifndef SYNTH
`define LFFC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lffc: implication check failed");
`define LFFC_ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("lffc: forbidden condition seen");
`else
`define LFFC_ASSERT_IMP(label, clk, rst, ante, cons)
`define LFFC_ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

[rtl/core/lffc_pkg.sv]
// ----------------------------------------------------------------------------
// LED flash/fade controller package
// Widths, codes, entry and result types shared by the core modules.
// ----------------------------------------------------------------------------
`default_nettype none

package lffc_pkg;

  localparam int NUM_LEDS  = 11;
  localparam int ACT_W     = 3;
  localparam int IDX_W     = 4;
  localparam int MODE_W    = 3;
  localparam int LVL_W     = 16;
  localparam int REG_W     = 2;
  localparam int PTR_W     = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
  localparam int DIV_STEPS = LVL_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [ACT_W-1:0] ACT_SET     = 3'd0;
  localparam logic [ACT_W-1:0] ACT_REFRESH = 3'd1;
  localparam logic [ACT_W-1:0] ACT_SLOW    = 3'd2;
  localparam logic [ACT_W-1:0] ACT_FAST    = 3'd3;
  localparam logic [ACT_W-1:0] ACT_FADE    = 3'd4;
  localparam logic [ACT_W-1:0] ACT_READ    = 3'd5;

  localparam logic [MODE_W-1:0] MODE_SOLID      = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SLOW_FLASH = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SLOW_FADE  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_FAST_FLASH = 3'd3;
  localparam logic [MODE_W-1:0] MODE_FAST_FADE  = 3'd4;

  localparam logic [REG_W-1:0] REG_SELF_TEST = 2'd0;
  localparam logic [REG_W-1:0] REG_SLOW_DIV  = 2'd1;
  localparam logic [REG_W-1:0] REG_FAST_DIV  = 2'd2;

  localparam logic [LVL_W-1:0] SLOW_DIV_RST = 16'd100;
  localparam logic [LVL_W-1:0] FAST_DIV_RST = 16'd25;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [LVL_W-1:0]  target;
    logic [LVL_W-1:0]  level;
    logic [LVL_W-1:0]  step;
    logic              rising;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  localparam entry_t ENTRY_RST = '{
    mode:   '0,
    target: '0,
    level:  '0,
    step:   '0,
    rising: 1'b1
  };

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [IDX_W-1:0]  led_index;
    logic [MODE_W-1:0] led_mode;
    logic [LVL_W-1:0]  target_level;
  } item_t;

  typedef struct packed {
    logic             self_test;
    logic [LVL_W-1:0] slow_div;
    logic [LVL_W-1:0] fast_div;
  } cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0]  index;
    logic              is_drive;
    logic [LVL_W-1:0]  level;
    logic [MODE_W-1:0] mode;
    logic [LVL_W-1:0]  target;
    logic              rising;
  } res_t;

  typedef struct packed {
    logic push;
    logic close;
  } oq_ctl_t;

  typedef struct packed {
    logic ready;
    logic held;
  } oq_stat_t;

endpackage

`default_nettype wire

[rtl/core/lffc_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lffc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/core/lffc_div.sv]
// ----------------------------------------------------------------------------
// Fade step divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lffc_div (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [lffc_pkg::LVL_W-1:0] dividend,
  input  logic [lffc_pkg::LVL_W-1:0] divisor,
  output logic                    done,
  output logic [lffc_pkg::LVL_W-1:0] quotient
);

  import lffc_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [LVL_W-1:0]     rem;
  logic [LVL_W-1:0]     dvs;
  logic [LVL_W:0]       shifted;
  logic [LVL_W:0]       diff;
  logic                 ge;

  assign shifted = {rem, quotient[LVL_W-1]};
  assign ge      = shifted >= {1'b0, dvs};
  assign diff    = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
      cnt      <= '0;
    end else if (busy) begin
      rem      <= ge ? diff[LVL_W-1:0] : shifted[LVL_W-1:0];
      quotient <= {quotient[LVL_W-2:0], ge};
      cnt      <= cnt + DIV_CNT_W'(1);
    end
  end

endmodule

`default_nettype wire

[rtl/core/lffc_outq.sv]
// ----------------------------------------------------------------------------
// Result staging
// Hold the newest result until the next one or the end of the walk marks
// whether it is final, then pass it to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lffc_outq (
  input  logic               clk,
  input  logic               rst,
  input  lffc_pkg::oq_ctl_t  ctl,
  input  lffc_pkg::res_t     res_in,
  output lffc_pkg::oq_stat_t stat,
  input  logic               out_stall,
  output logic               out_valid,
  output lffc_pkg::res_t     out_res,
  output logic               out_last
);

  import lffc_pkg::*;

  logic held_v;
  res_t held;
  logic out_free;
  logic move;

  assign out_free   = !out_valid || !out_stall;
  assign stat.ready = !held_v || out_free;
  assign stat.held  = held_v;
  assign move       = held_v && (ctl.push || ctl.close);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      held_v    <= 1'b0;
    end else begin
      if (move) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (ctl.push) begin
        held_v <= 1'b1;
      end else if (ctl.close) begin
        held_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_res  <= held;
      out_last <= ctl.close;
    end
    if (ctl.push) begin
      held <= res_in;
    end
  end

endmodule

`default_nettype wire

[rtl/core/lffc_engine.sv]
// ----------------------------------------------------------------------------
// LED table engine
// Walk the entry RAM: read, update, write back and emit results.
// ----------------------------------------------------------------------------
`default_nettype none

module lffc_engine (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  lffc_pkg::item_t    item,
  input  lffc_pkg::cfg_t     cfg,
  input  lffc_pkg::oq_stat_t oq_stat,
  output logic               busy,
  output lffc_pkg::oq_ctl_t  oq_ctl,
  output lffc_pkg::res_t     res
);

  import lffc_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_EV   = 3'd2;
  localparam logic [2:0] S_DV   = 3'd3;
  localparam logic [2:0] S_UP   = 3'd4;
  localparam logic [2:0] S_PU   = 3'd5;
  localparam logic [2:0] S_CL   = 3'd6;

  logic [2:0]          st;
  logic [ACT_W-1:0]    act;
  logic [IDX_W-1:0]    idx;
  logic [PTR_W-1:0]    ptr;
  logic [NUM_LEDS-1:0] vld;
  entry_t              ent;
  entry_t              rd_ent;
  entry_t              upd;
  entry_t              wr_ent;
  logic [ENTRY_W-1:0]  rdata;
  logic                we;
  logic [PTR_W-1:0]    waddr;
  logic                in_range;
  logic                hit;
  logic                need_div;
  logic                at_end;
  logic [LVL_W-1:0]    div_sel;
  logic [LVL_W-1:0]    div_dvs;
  logic [LVL_W-1:0]    quo;
  logic                div_done;
  logic [LVL_W-1:0]    drv_lvl;
  logic [LVL_W:0]      sum;

  assign busy     = st != S_IDLE;
  assign in_range = {1'b0, item.led_index} < (IDX_W + 1)'(NUM_LEDS);
  assign rd_ent   = vld[ptr] ? entry_t'(rdata) : ENTRY_RST;
  assign at_end   = ptr == PTR_W'(NUM_LEDS - 1);

  always_comb begin
    unique case (act)
      ACT_REFRESH: hit = rd_ent.mode == MODE_SOLID;
      ACT_SLOW:    hit = rd_ent.mode == MODE_SLOW_FLASH;
      ACT_FAST:    hit = rd_ent.mode == MODE_FAST_FLASH;
      ACT_FADE:    hit = rd_ent.mode == MODE_SLOW_FADE || rd_ent.mode == MODE_FAST_FADE;
      default:     hit = 1'b0;
    endcase
  end

  assign need_div = hit && act == ACT_FADE && rd_ent.step == '0;
  assign div_sel  = (rd_ent.mode == MODE_SLOW_FADE) ? cfg.slow_div : cfg.fast_div;
  assign div_dvs  = (div_sel == '0) ? LVL_W'(1) : div_sel;

  lffc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (st == S_EV && need_div),
    .dividend (rd_ent.target),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (quo)
  );

  always_comb begin
    upd     = ent;
    drv_lvl = '0;
    sum     = {1'b0, ent.level} + {1'b0, ent.step};
    case (act) inside
      ACT_REFRESH: begin
        upd.level = ent.target;
        drv_lvl   = ent.target;
      end
      ACT_SLOW, ACT_FAST: begin
        if (ent.level == '0) begin
          upd.level = ent.target;
          drv_lvl   = ent.target;
        end else begin
          upd.level = '0;
        end
      end
      ACT_FADE: begin
        if (ent.rising) begin
          if (sum >= {1'b0, ent.target}) begin
            upd.level  = ent.target;
            upd.rising = 1'b0;
          end else begin
            upd.level = sum[LVL_W-1:0];
          end
        end else begin
          if (ent.level <= ent.step) begin
            upd.level  = '0;
            upd.rising = 1'b1;
          end else begin
            upd.level = ent.level - ent.step;
          end
        end
        drv_lvl = upd.level;
      end
      default: ;
    endcase
  end

  assign we     = (st == S_IDLE && start && item.action == ACT_SET && in_range) || st == S_UP;
  assign waddr  = (st == S_UP) ? ptr : item.led_index[PTR_W-1:0];
  assign wr_ent = (st == S_UP) ? upd : entry_t'{
    mode:   item.led_mode,
    target: item.target_level,
    level:  '0,
    step:   '0,
    rising: 1'b1
  };

  lffc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_LEDS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wr_ent),
    .raddr (ptr),
    .rdata (rdata)
  );

  assign oq_ctl.push  = st == S_PU && oq_stat.ready;
  assign oq_ctl.close = st == S_CL && oq_stat.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      st  <= S_IDLE;
      vld <= '0;
    end else begin
      if (we) begin
        vld[waddr] <= 1'b1;
      end
      unique case (st)
        S_IDLE: begin
          if (start) begin
            act <= item.action;
            idx <= item.led_index;
            case (item.action) inside
              ACT_REFRESH, ACT_SLOW, ACT_FAST, ACT_FADE: begin
                ptr <= '0;
                st  <= S_RD;
              end
              ACT_READ: begin
                if (in_range) begin
                  ptr <= item.led_index[PTR_W-1:0];
                  st  <= S_RD;
                end else begin
                  res <= '{index: item.led_index, is_drive: 1'b0, level: '0,
                           mode: '0, target: '0, rising: 1'b0};
                  st  <= S_PU;
                end
              end
              default: ;
            endcase
          end
        end
        S_RD: st <= S_EV;
        S_EV: begin
          ent <= rd_ent;
          if (act == ACT_READ) begin
            res <= '{index: idx, is_drive: 1'b0, level: rd_ent.level,
                     mode: rd_ent.mode, target: rd_ent.target, rising: rd_ent.rising};
            st  <= S_PU;
          end else if (need_div) begin
            st <= S_DV;
          end else if (hit) begin
            st <= S_UP;
          end else if (at_end) begin
            st <= S_CL;
          end else begin
            ptr <= ptr + PTR_W'(1);
            st  <= S_RD;
          end
        end
        S_DV: begin
          if (div_done) begin
            ent.step <= quo;
            st       <= S_UP;
          end
        end
        S_UP: begin
          res <= '{index: IDX_W'(ptr), is_drive: 1'b1, level: drv_lvl,
                   mode: '0, target: '0, rising: 1'b0};
          if (!cfg.self_test) begin
            st <= S_PU;
          end else if (at_end) begin
            st <= S_CL;
          end else begin
            ptr <= ptr + PTR_W'(1);
            st  <= S_RD;
          end
        end
        S_PU: begin
          if (oq_stat.ready) begin
            if (act == ACT_READ || at_end) begin
              st <= S_CL;
            end else begin
              ptr <= ptr + PTR_W'(1);
              st  <= S_RD;
            end
          end
        end
        S_CL: begin
          if (oq_stat.ready) begin
            st <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/core/led_flash_fade_controller_core.sv]
// ----------------------------------------------------------------------------
// LED flash/fade controller core
// Table of LED entries in RAM driven by set, refresh, tick and read commands.
//
//   channel  handshake            payload
//   in       in_valid/in_stall    action, led_index, led_mode, target_level
//   out      out_valid/out_stall  out_index .. report_rising, last
//   cfg      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A set writes its entry from idle; a read passes through the read and
// evaluate states, but skips them for an index beyond the table.
// A tick or refresh walks all entries: a skipped entry passes through read
// and evaluate, a matching entry also through update and push (no push under
// self test), a zero fade step is divided first, and a close state finishes.
// Reset clears the per-entry valid bits; no clearing pass.
// Output stall holds the walk at the next result until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none
`include "led_flash_fade_controller_core_macros.svh"

module led_flash_fade_controller_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [lffc_pkg::ACT_W-1:0]   action,
  input  logic [lffc_pkg::IDX_W-1:0]   led_index,
  input  logic [lffc_pkg::MODE_W-1:0]  led_mode,
  input  logic [lffc_pkg::LVL_W-1:0]   target_level,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [lffc_pkg::IDX_W-1:0]   out_index,
  output logic                         is_drive,
  output logic [lffc_pkg::LVL_W-1:0]   pwm_level,
  output logic [lffc_pkg::MODE_W-1:0]  report_mode,
  output logic [lffc_pkg::LVL_W-1:0]   report_target,
  output logic                         report_rising,
  output logic                         last,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [lffc_pkg::REG_W-1:0]   cfg_index,
  input  logic [lffc_pkg::LVL_W-1:0]   cfg_data
);

  import lffc_pkg::*;

  cfg_t     cfg;
  item_t    item;
  res_t     res;
  res_t     out_res;
  oq_ctl_t  oq_ctl;
  oq_stat_t oq_stat;
  logic     busy;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.self_test <= 1'b0;
      cfg.slow_div  <= SLOW_DIV_RST;
      cfg.fast_div  <= FAST_DIV_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SELF_TEST: cfg.self_test <= cfg_data[0];
        REG_SLOW_DIV:  cfg.slow_div  <= cfg_data;
        REG_FAST_DIV:  cfg.fast_div  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign item     = '{action: action, led_index: led_index, led_mode: led_mode,
                      target_level: target_level};
  assign in_stall = busy;

  lffc_engine u_engine (
    .clk     (clk),
    .rst     (rst),
    .start   (in_valid && !in_stall),
    .item    (item),
    .cfg     (cfg),
    .oq_stat (oq_stat),
    .busy    (busy),
    .oq_ctl  (oq_ctl),
    .res     (res)
  );

  lffc_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .ctl       (oq_ctl),
    .res_in    (res),
    .stat      (oq_stat),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_res   (out_res),
    .out_last  (last)
  );

  assign out_index     = out_res.index;
  assign is_drive      = out_res.is_drive;
  assign pwm_level     = out_res.level;
  assign report_mode   = out_res.mode;
  assign report_target = out_res.target;
  assign report_rising = out_res.rising;

  // idle engine leaves no result waiting for its final mark
  `LFFC_ASSERT_IMP(a_idle_drained, clk, rst, !in_stall, !oq_stat.held)
  `LFFC_ASSERT_IMP(a_move_ready, clk, rst, oq_ctl.push || oq_ctl.close, oq_stat.ready)
  `LFFC_ASSERT_NEVER(a_push_close, clk, rst, oq_ctl.push && oq_ctl.close)

endmodule

`default_nettype wire
